@@ design/ifsf_pkg.sv @@
// ifsf_pkg: constants, queue entry type and stuffing helpers for the
// information-frame stuffing framer. No dependencies.
package ifsf_pkg;

	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [7:0] ADDR_BYTE   = 8'h03;
	localparam logic [7:0] CTRL_SEQ0   = 8'h00;
	localparam logic [7:0] CTRL_SEQ1   = 8'h40;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;
	localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
	localparam logic [7:0] ESC_OF_ESC  = 8'h5D;

	localparam int QUEUE_DEPTH_DEF = 2;

	// one classified request, as the back end expands it
	typedef struct packed {
		logic       hdr;     // opens a frame
		logic       seq;     // sequence bit for the control byte
		logic [7:0] data;
		logic       last;    // closes the frame
		logic [7:0] check;   // running XOR including data
	} ifsf_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ifsf_q_status_t;

	function automatic logic needs_esc(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	function automatic logic [7:0] esc_code(input logic [7:0] b);
		return (b == FLAG_BYTE) ? ESC_OF_FLAG : ESC_OF_ESC;
	endfunction

endpackage

@@ design/ifsf_in_if.sv @@
// ifsf_in_if: payload-byte channel, valid/ready handshake.
// Depends on nothing.
interface ifsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

@@ design/ifsf_out_if.sv @@
// ifsf_out_if: line-byte channel, valid/ready handshake.
// Depends on nothing.
interface ifsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       run_end;

	modport source(output valid, line_byte, run_end, input ready);
	modport sink(input valid, line_byte, run_end, output ready);
endinterface

@@ design/ifsf_front.sv @@
// ifsf_front: accepts payload bytes, tracks frame, sequence and running XOR,
// and pushes one classified entry per request. Uses ifsf_pkg, ifsf_in_if.
module ifsf_front
	import ifsf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ifsf_in_if.sink         in_ch,
	input  ifsf_q_status_t  q_status,
	output logic            push,
	output ifsf_entry_t     push_entry
);

	logic       in_frame_q;
	logic       seq_q;
	logic [7:0] parity_q;
	logic [7:0] parity_new;

	assign in_ch.ready = !q_status.full;
	assign push        = in_ch.valid && in_ch.ready;

	assign parity_new = (in_frame_q ? parity_q : 8'h00) ^ in_ch.data_byte;

	always_comb begin
		push_entry.hdr   = !in_frame_q;
		push_entry.seq   = seq_q;
		push_entry.data  = in_ch.data_byte;
		push_entry.last  = in_ch.last_byte;
		push_entry.check = parity_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			seq_q      <= 1'b0;
			parity_q   <= 8'h00;
		end else if (push) begin
			if (!in_frame_q) begin
				seq_q <= !seq_q;
			end
			in_frame_q <= !in_ch.last_byte;
			parity_q   <= in_ch.last_byte ? 8'h00 : parity_new;
		end
	end

endmodule

@@ design/ifsf_queue.sv @@
// ifsf_queue: small FIFO of classified entries between front and back end.
// Uses ifsf_pkg.
module ifsf_queue
	import ifsf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ifsf_entry_t    push_entry,
	input  logic           pop,
	output ifsf_entry_t    head,
	output ifsf_q_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ifsf_entry_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/ifsf_back.sv @@
// ifsf_back: expands the head entry into header (frame start), stuffed data,
// stuffed check and closing flag (frame end), one byte per cycle into the output
// register unless out_ch stalls. Uses ifsf_pkg, ifsf_out_if.
module ifsf_back
	import ifsf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  ifsf_entry_t     head,
	input  ifsf_q_status_t  q_status,
	output logic            pop,
	ifsf_out_if.source      out_ch
);

	typedef enum logic [3:0] {
		P_START, P_FLAG, P_ADDR, P_CTRL, P_HCS,
		P_DATA, P_DESC, P_CHK, P_CESC, P_CLOSE
	} phase_t;

	phase_t     phase_q;
	phase_t     cur;
	phase_t     nxt;
	logic [7:0] ctrl;
	logic [7:0] byte_d;
	logic       done;
	logic       load;
	logic       step;
	logic       valid_q;
	logic [7:0] line_q;
	logic       end_q;

	assign load = !valid_q || out_ch.ready;
	assign step = load && !q_status.empty;
	assign pop  = step && done;
	assign ctrl = head.seq ? CTRL_SEQ1 : CTRL_SEQ0;

	assign out_ch.valid     = valid_q;
	assign out_ch.line_byte = line_q;
	assign out_ch.run_end   = end_q;

	always_comb begin
		cur    = (phase_q == P_START) ? (head.hdr ? P_FLAG : P_DATA) : phase_q;
		nxt    = P_START;
		byte_d = FLAG_BYTE;
		done   = 1'b0;
		case (cur)
			P_FLAG: begin
				byte_d = FLAG_BYTE;
				nxt    = P_ADDR;
			end
			P_ADDR: begin
				byte_d = ADDR_BYTE;
				nxt    = P_CTRL;
			end
			P_CTRL: begin
				byte_d = ctrl;
				nxt    = P_HCS;
			end
			P_HCS: begin
				byte_d = ADDR_BYTE ^ ctrl;
				nxt    = P_DATA;
			end
			P_DATA: begin
				if (needs_esc(head.data)) begin
					byte_d = ESC_BYTE;
					nxt    = P_DESC;
				end else begin
					byte_d = head.data;
					nxt    = head.last ? P_CHK : P_START;
					done   = !head.last;
				end
			end
			P_DESC: begin
				byte_d = esc_code(head.data);
				nxt    = head.last ? P_CHK : P_START;
				done   = !head.last;
			end
			P_CHK: begin
				if (needs_esc(head.check)) begin
					byte_d = ESC_BYTE;
					nxt    = P_CESC;
				end else begin
					byte_d = head.check;
					nxt    = P_CLOSE;
				end
			end
			P_CESC: begin
				byte_d = esc_code(head.check);
				nxt    = P_CLOSE;
			end
			P_CLOSE: begin
				byte_d = FLAG_BYTE;
				nxt    = P_START;
				done   = 1'b1;
			end
			default: begin
				byte_d = FLAG_BYTE;
				nxt    = P_START;
				done   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_START;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_status.empty;
			if (step) begin
				phase_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			line_q <= byte_d;
			end_q  <= done;
		end
	end

endmodule

@@ design/info_frame_stuffing_framer.sv @@
// info_frame_stuffing_framer: top level, front end, entry queue and back end.
// Uses ifsf_pkg, ifsf_in_if, ifsf_out_if, ifsf_front, ifsf_queue, ifsf_back.
//
// Usage:
//  in_ch carries payload bytes (data_byte) with last_byte set on the final
//  byte of a frame; out_ch carries the line stream (line_byte) with run_end
//  set on the last line byte produced for each payload byte.
//  The first byte of a frame emits flag, address, control (sequence bit
//  toggles per frame) and header check ahead of the stuffed byte; the last
//  byte appends the stuffed XOR check and a closing flag.
//  A request accepted on in_ch is written into the entry queue; its first line
//  byte is then loaded into the output register, from which out_ch takes it.
//  Throughput: one line byte per cycle on out_ch while it is ready; a request
//  expands to 1 to 9 line bytes (header 4, escapes 1 each, trailer 2 or 3).
//  The front end accepts as long as the entry queue (QUEUE_DEPTH) has room,
//  so requests keep flowing while the back end drains earlier ones.
//  Reset clears frame, sequence and parity state, the queue and out valid.
//  When out_ch stalls, the output byte holds; the queue fills and then
//  in_ch.ready drops.
module info_frame_stuffing_framer
	import ifsf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ifsf_in_if.sink     in_ch,
	ifsf_out_if.source  out_ch
);

	ifsf_q_status_t q_status;
	ifsf_entry_t    push_entry;
	ifsf_entry_t    head;
	logic           push;
	logic           pop;

	ifsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	ifsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	ifsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

@@ design/ifsf_checker.sv @@
// ifsf_checker: port-level assertions for info_frame_stuffing_framer, and
// its bind. Uses ifsf_pkg.
module ifsf_checker
	import ifsf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] line_byte,
	input logic       run_end
);

	logic       in_acc;
	logic       out_acc;
	logic       done_acc;
	logic [7:0] pend_q;
	logic       esc_q;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign done_acc = out_acc && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'h00;
			esc_q  <= 1'b0;
		end else begin
			if (in_acc && !done_acc) begin
				pend_q <= pend_q + 1'b1;
			end else if (done_acc && !in_acc) begin
				pend_q <= pend_q - 1'b1;
			end
			if (out_acc) begin
				esc_q <= (line_byte == ESC_BYTE) && !esc_q;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_byte) && $stable(run_end))
		else $error("output changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'h00)
		else $error("output without pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 8'(QUEUE_DEPTH + 1))
		else $error("too many requests in flight");

	a_escape: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q && out_acc |-> (line_byte == ESC_OF_FLAG || line_byte == ESC_OF_ESC)
			&& !(esc_q && run_end && line_byte == ESC_BYTE))
		else $error("escape not followed by escape code");

endmodule

bind info_frame_stuffing_framer ifsf_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_ifsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.line_byte (out_ch.line_byte),
	.run_end   (out_ch.run_end)
);

@@ dv/ifsf_line_checker.sv @@
// ifsf_line_checker: watches both channels of the framer, expands every accepted
// request into the line bytes it must produce and compares them in order.
// Depends on ifsf_pkg, ifsf_in_if and ifsf_out_if.
module ifsf_line_checker
	import ifsf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	ifsf_in_if    in_ch,
	ifsf_out_if   out_ch,
	output int    error_count,
	output int    pending_lines
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_end;
	} line_beat_t;

	line_beat_t line_q[$];
	logic       open_frame = 1'b0;
	logic [7:0] frame_xor = 8'h00;
	logic       seq_bit = 1'b0;
	int         fail_total = 0;

	function automatic void push_stuffed(input logic [7:0] b);
		if (b == FLAG_BYTE || b == ESC_BYTE) begin
			line_q.push_back('{ESC_BYTE, 1'b0});
			line_q.push_back('{(b == FLAG_BYTE) ? ESC_OF_FLAG : ESC_OF_ESC, 1'b0});
		end else begin
			line_q.push_back('{b, 1'b0});
		end
	endfunction

	function automatic void expand_request(input logic [7:0] payload, input logic closes);
		logic [7:0] ctrl;
		if (!open_frame) begin
			ctrl = seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
			line_q.push_back('{FLAG_BYTE, 1'b0});
			line_q.push_back('{ADDR_BYTE, 1'b0});
			line_q.push_back('{ctrl, 1'b0});
			line_q.push_back('{ADDR_BYTE ^ ctrl, 1'b0});
			seq_bit = !seq_bit;
			frame_xor = 8'h00;
			open_frame = 1'b1;
		end
		push_stuffed(payload);
		frame_xor = frame_xor ^ payload;
		if (closes) begin
			push_stuffed(frame_xor);
			line_q.push_back('{FLAG_BYTE, 1'b0});
			open_frame = 1'b0;
			frame_xor = 8'h00;
		end
		line_q[line_q.size() - 1].run_end = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_beat_t want;
		if (!arst_n) begin
			line_q.delete();
			open_frame = 1'b0;
			frame_xor = 8'h00;
			seq_bit = 1'b0;
			pending_lines <= 0;
			error_count <= fail_total;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (line_q.size() == 0) begin
					$error("line byte %h with nothing pending", out_ch.line_byte);
					fail_total++;
				end else begin
					want = line_q.pop_front();
					if (out_ch.line_byte !== want.line_byte) begin
						$error("line_byte mismatch: expected %h, actual %h",
							want.line_byte, out_ch.line_byte);
						fail_total++;
					end
					if (out_ch.run_end !== want.run_end) begin
						$error("run_end mismatch: expected %b, actual %b",
							want.run_end, out_ch.run_end);
						fail_total++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expand_request(in_ch.data_byte, in_ch.last_byte);
			pending_lines <= line_q.size();
			error_count <= fail_total;
		end
	end

endmodule

@@ dv/testbench.sv @@
// testbench: clock, reset and request stimulus for info_frame_stuffing_framer,
// with random idling on both channels; checking is done by ifsf_line_checker.
// Depends on ifsf_pkg, ifsf_in_if, ifsf_out_if, the framer and the checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ifsf_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 35;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_REQUESTS = 370;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   error_count;
	int   pending_lines;
	int   sent = 0;
	logic in_gaps = 1'b1;
	logic out_gaps = 1'b1;
	logic hold_req = 1'b0;
	int   hold_left = 0;

	ifsf_in_if  in_ch();
	ifsf_out_if out_ch();

	info_frame_stuffing_framer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	ifsf_line_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.error_count   (error_count),
		.pending_lines (pending_lines)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(out_gaps && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic offer(input logic [7:0] payload, input logic closes);
		while (in_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= payload;
		in_ch.last_byte <= closes;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_lines != 0);
	endtask

	task automatic random_frame();
		int unsigned span;
		logic [7:0]  b;
		span = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(6, 1);
		for (int i = 0; i < span; i++) begin
			case ($urandom_range(9))
				0: b = FLAG_BYTE;
				1: b = ESC_BYTE;
				default: b = 8'($urandom_range(255));
			endcase
			offer(b, i == span - 1);
		end
	endtask

	initial begin
		int base;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.last_byte <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte frames and a five-byte frame: stuffed data and stuffed check
		offer(FLAG_BYTE, 1'b1);
		offer(ESC_BYTE, 1'b1);
		offer(8'h00, 1'b0);
		offer(8'hFF, 1'b0);
		offer(FLAG_BYTE, 1'b0);
		offer(ESC_BYTE, 1'b0);
		offer(8'h55, 1'b1);
		// check comes out as flag, then as escape
		offer(8'h12, 1'b0);
		offer(8'h6C, 1'b1);
		offer(FLAG_BYTE, 1'b0);
		offer(ADDR_BYTE, 1'b1);
		// check of zero
		offer(8'hAA, 1'b0);
		offer(8'hAA, 1'b1);
		offer(8'hFF, 1'b1);
		base = sent;

		while (sent < base + 120)
			random_frame();

		// no idling; receiver holds off long enough to back up the input
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		hold_req = 1'b1;
		while (sent < base + 240)
			random_frame();

		wait_drained();
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		while (sent < base + RANDOM_REQUESTS)
			random_frame();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
